// ===== src/bbq_pkg.sv =====
// Shared types and constants for the billboard quad expander.
// No dependencies; every other source file but bbq_if refers to this package by scoped names.
package bbq_pkg;

  localparam int MAX_PARTICLES_DEF = 4096;
  localparam int VIDX_W = 14;
  localparam int NMAG_W = 17;    // normalized magnitude, at most 1.0 in Q1.16
  localparam int SVEC_W = 33;    // scaled axis component, signed
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [2:0] REG_RIGHT_X = 3'd0;
  localparam logic [2:0] REG_RIGHT_Y = 3'd1;
  localparam logic [2:0] REG_RIGHT_Z = 3'd2;
  localparam logic [2:0] REG_UP_X    = 3'd3;
  localparam logic [2:0] REG_UP_Y    = 3'd4;
  localparam logic [2:0] REG_UP_Z    = 3'd5;
  localparam int NUM_REGS = 6;

  localparam logic [1:0] CORNER_BL = 2'd0;
  localparam logic [1:0] CORNER_BR = 2'd1;
  localparam logic [1:0] CORNER_TR = 2'd2;
  localparam logic [1:0] CORNER_TL = 2'd3;

  typedef enum logic [2:0] {
    NORM_IDLE,
    NORM_SQ,
    NORM_ROOT,
    NORM_LOAD,
    NORM_DIV
  } norm_state_t;

  typedef enum logic {
    ENT_QUAD,
    ENT_CLEAR
  } ent_kind_t;

  // Normalized camera axes: [axis][component], axis 0 right, 1 up.
  typedef struct packed {
    logic [1:0][2:0][NMAG_W-1:0] mag;
    logic [1:0][2:0]             neg;
  } nvec_t;

  typedef struct packed {
    ent_kind_t                   kind;
    logic                        frame_end;
    logic [2:0][31:0]            pos;
    logic [2:0][SVEC_W-1:0]      sr;
    logic [2:0][SVEC_W-1:0]      su;
  } entry_t;

endpackage

// ===== src/bbq_if.sv =====
// Valid/ready channel interfaces for particles in and corners out.
// Depends on nothing.
interface bbq_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [30:0] half_size;
  logic [31:0] life;
  logic        frame_end;
  modport source (output valid, pos_x, pos_y, pos_z, half_size, life, frame_end,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, half_size, life, frame_end,
                output ready);
endinterface

interface bbq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] corner_x;
  logic [31:0] corner_y;
  logic [31:0] corner_z;
  logic [13:0] vertex_index;
  logic [1:0]  corner_id;
  logic        last_corner;
  modport source (output valid, corner_x, corner_y, corner_z, vertex_index, corner_id,
                  last_corner, input ready);
  modport sink (input valid, corner_x, corner_y, corner_z, vertex_index, corner_id,
                last_corner, output ready);
endinterface

// ===== src/bbq_norm.sv =====
// Camera axis registers and the iterative normalizer (square sum, root, divide).
// Depends on bbq_pkg.
module bbq_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                busy,
  output bbq_pkg::nvec_t      nvec
);

  logic [31:0]          cfg_r [bbq_pkg::NUM_REGS];
  logic                 start_r, start_nxt;
  bbq_pkg::norm_state_t state_r, state_nxt;
  logic                 axis_r, axis_nxt;
  logic [1:0]           comp_r, comp_nxt;
  logic [4:0]           step_r, step_nxt;
  logic [63:0]          acc_r, acc_nxt;
  logic [63:0]          root_r, root_nxt;
  logic [63:0]          bit_r, bit_nxt;
  logic [47:0]          rem_r, rem_nxt;
  logic [bbq_pkg::NMAG_W-1:0] q_r, q_nxt;
  bbq_pkg::nvec_t       nvec_r, nvec_nxt;

  logic [2:0]  raw_idx;
  logic [31:0] raw;
  logic [31:0] raw_mag;
  logic [63:0] sq;
  logic [63:0] trial_root;
  logic [31:0] len;
  logic [48:0] trial_div;
  logic        wr_hit;

  assign wr_hit  = cfg_we && (cfg_index < 3'(bbq_pkg::NUM_REGS));
  assign raw_idx = axis_r ? (3'(comp_r) + bbq_pkg::REG_UP_X) : 3'(comp_r);
  assign raw     = cfg_r[raw_idx];
  assign raw_mag = raw[31] ? (32'd0 - raw) : raw;
  assign sq      = 64'(raw_mag) * 64'(raw_mag);
  assign trial_root = root_r + bit_r;
  assign len       = root_r[31:0];
  assign trial_div = 49'(len) << step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[bbq_pkg::REG_RIGHT_X] <= 32'd65536;
      cfg_r[bbq_pkg::REG_RIGHT_Y] <= 32'd0;
      cfg_r[bbq_pkg::REG_RIGHT_Z] <= 32'd0;
      cfg_r[bbq_pkg::REG_UP_X]    <= 32'd0;
      cfg_r[bbq_pkg::REG_UP_Y]    <= 32'd65536;
      cfg_r[bbq_pkg::REG_UP_Z]    <= 32'd0;
      start_r <= 1'b1;
      state_r <= bbq_pkg::NORM_IDLE;
    end else begin
      if (wr_hit) begin
        cfg_r[cfg_index] <= cfg_data;
      end
      start_r <= start_nxt;
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    axis_r <= axis_nxt;
    comp_r <= comp_nxt;
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    nvec_r <= nvec_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    axis_nxt  = axis_r;
    comp_nxt  = comp_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    nvec_nxt  = nvec_r;
    // a new write restarts the whole pass from the right axis
    if (start_r) begin
      state_nxt = bbq_pkg::NORM_SQ;
      axis_nxt  = 1'b0;
      comp_nxt  = 2'd0;
      acc_nxt   = 64'd0;
      start_nxt = 1'b0;
    end else begin
      case (state_r)
        bbq_pkg::NORM_IDLE: begin
        end
        bbq_pkg::NORM_SQ: begin
          acc_nxt  = acc_r + sq;
          comp_nxt = comp_r + 2'd1;
          if (comp_r == 2'd2) begin
            state_nxt = bbq_pkg::NORM_ROOT;
            root_nxt  = 64'd0;
            bit_nxt   = 64'd1 << 62;
            step_nxt  = 5'd0;
          end
        end
        bbq_pkg::NORM_ROOT: begin
          if (acc_r >= trial_root) begin
            acc_nxt  = acc_r - trial_root;
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt  = bit_r >> 2;
          step_nxt = step_r + 5'd1;
          if (step_r == 5'd31) begin
            state_nxt = bbq_pkg::NORM_LOAD;
            comp_nxt  = 2'd0;
          end
        end
        bbq_pkg::NORM_LOAD: begin
          rem_nxt   = {raw_mag, 16'd0};
          q_nxt     = '0;
          step_nxt  = 5'd16;
          state_nxt = bbq_pkg::NORM_DIV;
        end
        bbq_pkg::NORM_DIV: begin
          if (49'(rem_r) >= trial_div) begin
            rem_nxt        = 48'(49'(rem_r) - trial_div);
            q_nxt[step_r]  = 1'b1;
          end
          if (step_r == 5'd0) begin
            nvec_nxt.mag[axis_r][comp_r] = (len == 32'd0) ? '0 : q_nxt;
            nvec_nxt.neg[axis_r][comp_r] = raw[31];
            if (comp_r == 2'd2) begin
              if (!axis_r) begin
                axis_nxt  = 1'b1;
                comp_nxt  = 2'd0;
                acc_nxt   = 64'd0;
                state_nxt = bbq_pkg::NORM_SQ;
              end else begin
                state_nxt = bbq_pkg::NORM_IDLE;
              end
            end else begin
              comp_nxt  = comp_r + 2'd1;
              state_nxt = bbq_pkg::NORM_LOAD;
            end
          end else begin
            step_nxt = step_r - 5'd1;
          end
        end
        default: state_nxt = bbq_pkg::NORM_IDLE;
      endcase
    end
    if (wr_hit) begin
      start_nxt = 1'b1;
    end
  end

  assign busy = start_r || (state_r != bbq_pkg::NORM_IDLE);
  assign nvec = nvec_r;

endmodule

// ===== src/bbq_front.sv =====
// Front end: accepts particles, drops dead ones, scales the axes by size
// and pushes quad or counter-clear entries. Depends on bbq_pkg, bbq_if.
module bbq_front (
  input  logic            clk,
  input  logic            rst_n,
  bbq_in_if.sink          in_ch,
  input  logic            norm_busy,
  input  bbq_pkg::nvec_t  nvec,
  input  logic            q_full,
  output logic            q_push,
  output bbq_pkg::entry_t q_data
);

  logic        st_valid_r, st_valid_nxt;
  logic [2:0][31:0] pos_r;
  logic [30:0] size_r;
  logic [31:0] life_r;
  logic        fend_r;
  logic        live;
  logic        drop;
  logic        leave;
  logic [47:0] prod [2][3];
  logic [bbq_pkg::SVEC_W-1:0] sv [2][3];

  assign live  = !life_r[31] && (life_r != 32'd0);
  assign drop  = !live && !fend_r;
  assign leave = st_valid_r && (drop || !q_full);
  assign q_push = st_valid_r && !drop && !q_full;
  assign in_ch.ready = !norm_busy && (!st_valid_r || leave);

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int c = 0; c < 3; c++) begin
        prod[a][c] = 48'(nvec.mag[a][c]) * 48'(size_r);
        sv[a][c]   = nvec.neg[a][c] ? (33'd0 - {1'b0, prod[a][c][47:16]})
                                    : {1'b0, prod[a][c][47:16]};
      end
    end
    q_data.kind      = live ? bbq_pkg::ENT_QUAD : bbq_pkg::ENT_CLEAR;
    q_data.frame_end = fend_r;
    q_data.pos       = pos_r;
    for (int c = 0; c < 3; c++) begin
      q_data.sr[c] = sv[0][c];
      q_data.su[c] = sv[1][c];
    end
  end

  always_comb begin
    st_valid_nxt = st_valid_r && !leave;
    if (in_ch.valid && in_ch.ready) begin
      st_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= st_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      pos_r  <= {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
      size_r <= in_ch.half_size;
      life_r <= in_ch.life;
      fend_r <= in_ch.frame_end;
    end
  end

endmodule

// ===== src/bbq_fifo.sv =====
// Two-entry queue between the front and back ends.
// Depends on bbq_pkg.
module bbq_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bbq_pkg::entry_t wdata,
  input  logic            pop,
  output bbq_pkg::entry_t rdata,
  output logic            full,
  output logic            not_empty
);

  bbq_pkg::entry_t           mem_r [bbq_pkg::QDEPTH];
  logic [bbq_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [bbq_pkg::QCNT_W-1:0] cnt_r;

  assign full      = (cnt_r == bbq_pkg::QCNT_W'(bbq_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + bbq_pkg::QCNT_W'(push) - bbq_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= wdata;
  end

endmodule

// ===== src/bbq_back.sv =====
// Back end: walks the four corners of each quad into the output register
// and keeps the vertex counter. Depends on bbq_pkg, bbq_if.
module bbq_back #(
  parameter int MAX_PARTICLES = bbq_pkg::MAX_PARTICLES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  bbq_pkg::entry_t q_data,
  output logic            q_pop,
  bbq_out_if.source       out_ch
);

  localparam int CNT_LIM = 4 * MAX_PARTICLES;

  logic                      ovalid_r, ovalid_nxt;
  logic [2:0][31:0]          corner_r;
  logic [bbq_pkg::VIDX_W-1:0] vidx_r;
  logic [1:0]                id_r;
  logic                      last_r;
  logic [1:0]                k_r, k_nxt;
  logic [bbq_pkg::VIDX_W-1:0] cnt_r, cnt_nxt;
  logic [bbq_pkg::VIDX_W:0]   cnt_inc;
  logic                      emit;
  logic                      rplus, uplus;
  logic signed [34:0]        sum [3];
  logic [2:0][31:0]          corner_nxt;

  assign emit    = q_valid && (q_data.kind == bbq_pkg::ENT_QUAD) &&
                   (!ovalid_r || out_ch.ready);
  assign rplus   = (k_r == bbq_pkg::CORNER_BR) || (k_r == bbq_pkg::CORNER_TR);
  assign uplus   = (k_r == bbq_pkg::CORNER_TR) || (k_r == bbq_pkg::CORNER_TL);
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = 35'(signed'(q_data.pos[c]))
             + (rplus ? 35'(signed'(q_data.sr[c])) : -35'(signed'(q_data.sr[c])))
             + (uplus ? 35'(signed'(q_data.su[c])) : -35'(signed'(q_data.su[c])));
      if (sum[c] > 35'sd2147483647) begin
        corner_nxt[c] = 32'h7fff_ffff;
      end else if (sum[c] < -35'sd2147483648) begin
        corner_nxt[c] = 32'h8000_0000;
      end else begin
        corner_nxt[c] = sum[c][31:0];
      end
    end
  end

  always_comb begin
    q_pop      = 1'b0;
    k_nxt      = k_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    if (q_valid && (q_data.kind == bbq_pkg::ENT_CLEAR)) begin
      q_pop   = 1'b1;
      cnt_nxt = '0;
    end else if (emit) begin
      ovalid_nxt = 1'b1;
      k_nxt      = k_r + 2'd1;
      cnt_nxt    = (32'(cnt_inc) >= CNT_LIM) ? '0 : cnt_inc[bbq_pkg::VIDX_W-1:0];
      if (k_r == bbq_pkg::CORNER_TL) begin
        q_pop = 1'b1;
        if (q_data.frame_end) cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      k_r      <= bbq_pkg::CORNER_BL;
      cnt_r    <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      k_r      <= k_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      corner_r <= corner_nxt;
      vidx_r   <= cnt_r;
      id_r     <= k_r;
      last_r   <= (k_r == bbq_pkg::CORNER_TL);
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.corner_x     = corner_r[0];
  assign out_ch.corner_y     = corner_r[1];
  assign out_ch.corner_z     = corner_r[2];
  assign out_ch.vertex_index = vidx_r;
  assign out_ch.corner_id    = id_r;
  assign out_ch.last_corner  = last_r;

endmodule

// ===== src/billboard_quad_expander.sv =====
// Billboard quad expander top level: axis normalizer, front end, queue, back end.
// Depends on bbq_pkg, bbq_if, bbq_norm, bbq_front, bbq_fifo, bbq_back.
//
// Usage: particles arrive on in_ch (valid/ready), corners leave on out_ch.
// A live particle (life above zero) yields four corner transactions in the order
// bottom-left, bottom-right, top-right, top-left, each with the next vertex index;
// a dead one yields none. frame_end returns the index counter to zero after the
// particle. The camera axes are written through cfg_we/cfg_index/cfg_data.
// After reset and after each register write, the normalizer runs its steps
// (per axis: 3 squaring steps, 32 root steps, 3 x 18 divide steps), and
// in_ch.ready stays low meanwhile.
// An accepted particle passes the front-end register and the queue, then the back
// end fills the single output register one corner per cycle while the receiver
// takes them; a dead particle is queued only if it carries frame_end, as a clear.
// When the receiver stalls, the output register holds, the two-entry queue
// fills and then the front end stalls in_ch.
module billboard_quad_expander #(
  parameter int MAX_PARTICLES = bbq_pkg::MAX_PARTICLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bbq_in_if.sink      in_ch,
  bbq_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic            norm_busy;
  bbq_pkg::nvec_t  nvec;
  logic            q_push, q_pop, q_full, q_valid;
  bbq_pkg::entry_t q_wdata, q_rdata;

  bbq_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (norm_busy),
    .nvec      (nvec)
  );

  bbq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .norm_busy (norm_busy),
    .nvec      (nvec),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  bbq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .full      (q_full),
    .not_empty (q_valid)
  );

  bbq_back #(.MAX_PARTICLES(MAX_PARTICLES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    norm_busy |-> !(in_ch.valid && in_ch.ready))
    else $error("particle accepted while normalizer busy");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (!q_full || q_pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue pop while empty");

  a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && !out_ch.last_corner) |=>
      (out_ch.corner_id == $past(out_ch.corner_id) + 2'd1))
    else $error("corner order broken");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for billboard_quad_expander: camera-axis settings,
// particle stimulus and an independent corner predictor.
// Depends on bbq_pkg, bbq_if and billboard_quad_expander in src/.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [13:0] vidx;
    logic [1:0]  cid;
    logic        last;
  } corner_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  bbq_in_if  in_ch();
  bbq_out_if out_ch();

  billboard_quad_expander DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [31:0] cam_axes [bbq_pkg::NUM_REGS];
  logic [13:0] vtx_count;
  corner_t     corner_q [$];
  int          mismatches = 0;
  bit          idle_en = 1'b1;
  int          hold_cycles = 0;

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.half_size = '0;
    in_ch.life = '0;
    in_ch.frame_end = 1'b0;
    out_ch.ready = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Normalized component i of the axis starting at register base, scaled by size.
  function automatic longint scaled_comp(int base, int i, longint unsigned size);
    longint          v [3];
    longint unsigned m [3];
    longint unsigned sum = 0;
    longint unsigned len, n, s;
    for (int k = 0; k < 3; k++) begin
      v[k] = longint'(signed'(cam_axes[base + k]));
      m[k] = (v[k] < 0) ? longint'(-v[k]) : longint'(v[k]);
      sum += m[k] * m[k];
    end
    len = int_sqrt(sum);
    if (len == 0) return 0;
    n = (m[i] << 16) / len;
    s = (n * size) >> 16;
    return (v[i] < 0) ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void predict_quad(logic [31:0] p [3], logic [30:0] hs,
                                       logic [31:0] life, logic fe);
    longint  r [3];
    longint  u [3];
    longint  c [3];
    corner_t e;
    int      rs, us;
    if (signed'(life) > 0) begin
      for (int i = 0; i < 3; i++) begin
        r[i] = scaled_comp(0, i, {33'd0, hs});
        u[i] = scaled_comp(3, i, {33'd0, hs});
      end
      for (int k = 0; k < 4; k++) begin
        rs = (k == 1 || k == 2) ? 1 : -1;
        us = (k >= 2) ? 1 : -1;
        for (int i = 0; i < 3; i++)
          c[i] = longint'(signed'(p[i])) + rs * r[i] + us * u[i];
        e.cx = clamp32(c[0]);
        e.cy = clamp32(c[1]);
        e.cz = clamp32(c[2]);
        e.vidx = vtx_count;
        e.cid = 2'(k);
        e.last = (2'(k) == bbq_pkg::CORNER_TL);
        corner_q.push_back(e);
        if (32'(vtx_count) + 1 >= 4 * bbq_pkg::MAX_PARTICLES_DEF) vtx_count = '0;
        else vtx_count = vtx_count + 14'd1;
      end
    end
    if (fe) vtx_count = '0;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic [30:0] hs, logic [31:0] life, logic fe);
    logic [31:0] p [3];
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.pos_x = px;
    in_ch.pos_y = py;
    in_ch.pos_z = pz;
    in_ch.half_size = hs;
    in_ch.life = life;
    in_ch.frame_end = fe;
    do @(posedge clk); while (!in_ch.ready);
    predict_quad(p, hs, life, fe);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_drain();
    while (corner_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx < bbq_pkg::NUM_REGS) cam_axes[idx] = data;
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_size();
    case ($urandom_range(0, 7))
      0: return 31'h7FFF_FFFF;
      1: return 31'h0;
      2, 3, 4: return 31'($urandom_range(0, 32'h0008_0000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_life();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return $urandom | 32'h8000_0000;
      default: return ($urandom & 32'h7FFF_FFFF) | 32'h1;
    endcase
  endfunction

  task automatic send_random(int count);
    for (int n = 0; n < count; n++)
      send_particle(rand_q16(), rand_q16(), rand_q16(), rand_size(), rand_life(),
                    $urandom_range(0, 15) == 0);
  endtask

  task automatic set_axes(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                          logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
    write_reg(bbq_pkg::REG_RIGHT_X, rx);
    write_reg(bbq_pkg::REG_RIGHT_Y, ry);
    write_reg(bbq_pkg::REG_RIGHT_Z, rz);
    write_reg(bbq_pkg::REG_UP_X, ux);
    write_reg(bbq_pkg::REG_UP_Y, uy);
    write_reg(bbq_pkg::REG_UP_Z, uz);
  endtask

  // ---------------- result side ----------------
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready = 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  initial begin
    corner_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (corner_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected corner transaction: x=%h y=%h z=%h idx=%0d id=%0d",
                     out_ch.corner_x, out_ch.corner_y, out_ch.corner_z,
                     out_ch.vertex_index, out_ch.corner_id);
        end else begin
          e = corner_q.pop_front();
          if (out_ch.corner_x !== e.cx || out_ch.corner_y !== e.cy ||
              out_ch.corner_z !== e.cz || out_ch.vertex_index !== e.vidx ||
              out_ch.corner_id !== e.cid || out_ch.last_corner !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"corner mismatch: exp x=%h y=%h z=%h idx=%0d id=%0d last=%b,",
                        " got x=%h y=%h z=%h idx=%0d id=%0d last=%b"},
                       e.cx, e.cy, e.cz, e.vidx, e.cid, e.last,
                       out_ch.corner_x, out_ch.corner_y, out_ch.corner_z,
                       out_ch.vertex_index, out_ch.corner_id, out_ch.last_corner);
          end
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_default_axes();
    send_particle(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 31'h0001_0000,
                  32'h0001_0000, 1'b0);
    send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h7FFF_FFFF, 1'b0);
    send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                  32'h0000_0001, 1'b0);
    send_particle(32'h0, 32'h0, 32'h0, 31'h0, 32'h1, 1'b0);
    // dead particles: zero, minimum, minus one
    send_particle(32'h1234_5678, 32'h0, 32'h0, 31'h0001_0000, 32'h0, 1'b0);
    send_particle(32'h0, 32'h0, 32'h0, 31'h0001_0000, 32'h8000_0000, 1'b0);
    send_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h5555_5555,
                  32'hFFFF_FFFF, 1'b0);
    send_particle(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA,
                  32'h0100_0000, 1'b1);
    send_particle(32'h0, 32'h0, 32'h0, 31'h0001_0000, 32'h1, 1'b0);
    // dead particle that still closes the frame
    send_particle(32'h0, 32'h0, 32'h0, 31'h0001_0000, 32'h0, 1'b1);
    send_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 31'h5555_5555,
                  32'h1, 1'b0);
    stop_sending();
    wait_drain();
  endtask

  task automatic test_axis_extremes();
    set_axes(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_particle(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF, 32'h1, 1'b0);
    send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 31'h0001_0000, 32'h1, 1'b0);
    stop_sending();
    wait_drain();
    // both axes zero: quad collapses onto the center
    set_axes(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_particle(32'h0003_0000, 32'hFFFD_0000, 32'h0, 31'h7FFF_FFFF, 32'h1, 1'b0);
    stop_sending();
    wait_drain();
    // out-of-range register indexes must be ignored
    write_reg(3'd6, 32'h1234_5678);
    write_reg(3'd7, 32'hDEAD_BEEF);
    set_axes(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0003_0000);
    send_particle(32'h0, 32'h0, 32'h0, 31'h0123_4567, 32'h1, 1'b1);
    send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                  32'h1, 1'b0);
    stop_sending();
    wait_drain();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    set_axes(32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    // live particles with no idling on either side, then a frame close
    for (int n = 0; n < 8; n++)
      send_particle($urandom, $urandom, $urandom, 31'($urandom_range(0, 32'hFFFFF)),
                    32'h1, 1'b0);
    send_particle(32'h0, 32'h0, 32'h0, 31'h0, 32'h1, 1'b1);
    stop_sending();
    wait_drain();
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    send_random(14);
    stop_sending();
    wait_drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      set_axes(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
      if (phase == 5) idle_en = 1'b0;
      send_random(55);
      stop_sending();
      wait_drain();
    end
  endtask

  initial begin
    cam_axes[bbq_pkg::REG_RIGHT_X] = 32'h0001_0000;
    cam_axes[bbq_pkg::REG_RIGHT_Y] = 32'h0;
    cam_axes[bbq_pkg::REG_RIGHT_Z] = 32'h0;
    cam_axes[bbq_pkg::REG_UP_X] = 32'h0;
    cam_axes[bbq_pkg::REG_UP_Y] = 32'h0001_0000;
    cam_axes[bbq_pkg::REG_UP_Z] = 32'h0;
    vtx_count = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_axes();
    test_axis_extremes();
    test_backpressure();
    test_back_to_back();
    test_random();

    while (corner_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && corner_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
src/bbq_pkg.sv
src/bbq_if.sv
src/bbq_norm.sv
src/bbq_front.sv
src/bbq_fifo.sv
src/bbq_back.sv
src/billboard_quad_expander.sv
test/testbench.sv
